FILE: sv/cvsd_pkg.sv
// Package for the CAN vehicle signal decoder.
// Holds the input and result word types, the frame identifiers and the decode constants.
// It depends on nothing else.
`default_nettype none

package cvsd_pkg;

    localparam int NUM_BOUNDS = 5;
    localparam int BOUND_W    = 24;
    localparam int PRODUCT_W  = 40;

    typedef struct packed {
        logic [10:0] frame_id;
        logic [31:0] payload_high;
        logic [31:0] payload_low;
    } t_in_word;

    typedef struct packed {
        logic signed [16:0] speed_centi_kmh;
        logic [15:0]        rpm_quarter;
        logic [3:0]         gear_position;
        logic [7:0]         accel_half_percent;
        logic [9:0]         brake_tenth_percent;
        logic signed [15:0] steering_raw;
    } t_out_word;

    typedef logic [PRODUCT_W-1:0] t_product;

    localparam logic [10:0] ID_ENGINE_SPEED = 11'd513;
    localparam logic [10:0] ID_TRANSMISSION = 11'd561;
    localparam logic [10:0] ID_STEERING     = 11'd129;
    localparam logic [10:0] ID_BRAKE        = 11'd133;
    localparam logic [10:0] ID_REPORT       = 11'd1056;

    localparam logic [2:0] REG_SIX_FIVE    = 3'd0;
    localparam logic [2:0] REG_FIVE_FOUR   = 3'd1;
    localparam logic [2:0] REG_FOUR_THREE  = 3'd2;
    localparam logic [2:0] REG_THREE_TWO   = 3'd3;
    localparam logic [2:0] REG_TWO_ONE     = 3'd4;

    localparam logic [3:0] GEAR_NEUTRAL = 4'd0;
    localparam logic [3:0] GEAR_ONE     = 4'd1;
    localparam logic [3:0] GEAR_SIX     = 4'd6;
    localparam logic [3:0] GEAR_CLUTCH  = 4'd8;

    localparam logic [16:0]        SPEED_OFFSET   = 17'd10000;
    localparam logic signed [16:0] SPEED_DEAD     = 17'sd100;
    localparam logic [15:0]        RPM_MIN        = 16'd4;
    localparam logic signed [17:0] BRAKE_OFFSET   = 18'sd102;
    localparam logic signed [17:0] BRAKE_HALF_MAX = 18'sd500;
    localparam logic [9:0]         BRAKE_MAX      = 10'd1000;

endpackage

`default_nettype wire

FILE: sv/can_vehicle_signal_decoder.sv
// CAN vehicle signal decoder, top level.
// Decodes received frames into stored vehicle signals and reports them on request.
// Depends on cvsd_pkg.
//
// Input channel: one word per received frame (identifier and eight data bytes),
// taken at a rising edge where i_in_valid is high and o_in_stall is low.
// Output channel: one word holding all stored signals for each report frame,
// taken at a rising edge where o_out_valid is high and i_out_stall is low.
// Other frames update the stored signals and give no output word.
// Takes one frame per cycle while o_in_stall is low. A report word passes through one
// input register, one stage holding the five boundary products for the gear
// estimate, then the output register, before it appears on o_out_valid.
// The APB port writes and reads the five gear boundaries; pready is always high.
// Synchronous reset clears all stored signals, the boundaries and the pipeline.
// While the receiver stalls, the output word holds and frames keep flowing until
// a report frame waits behind the held word and one more frame fills the input
// register; only then is o_in_stall raised.
`default_nettype none

module can_vehicle_signal_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cvsd_pkg::t_in_word i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cvsd_pkg::t_out_word o_out_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import cvsd_pkg::*;

    logic [BOUND_W-1:0] r_bound [NUM_BOUNDS];
    logic               cfg_write;
    logic [2:0]         cfg_index;

    logic      r_a_valid;
    t_in_word  r_a_word;
    logic      r_b_valid;
    t_in_word  r_b_word;
    t_product  r_b_product [NUM_BOUNDS];
    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word n_out_word;

    logic [15:0] r_speed_word;
    logic [15:0] r_rpm_word;
    logic [7:0]  r_accel_byte;
    logic [3:0]  r_gear_code;
    logic        r_clutch_flag;
    logic        r_neutral_flag;
    logic [15:0] r_steering_word;
    logic [9:0]  r_brake_level;
    logic [3:0]  n_gear_code;
    logic [9:0]  n_brake_level;

    logic out_free;
    logic b_go;
    logic b_free;
    logic a_free;

    logic [16:0]        a_speed;
    logic [15:0]        b_rpm;
    logic signed [16:0] b_speed;
    logic [PRODUCT_W-1:0] b_lhs;
    logic signed [17:0] b_brake_diff;
    logic b_is_engine;
    logic b_is_trans;
    logic b_is_steer;
    logic b_is_brake;
    logic b_is_report;

    assign cfg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_BOUNDS; k++) begin
                r_bound[k] <= '0;
            end
        end else if (cfg_write) begin
            case (cfg_index)
                REG_SIX_FIVE:   r_bound[0] <= pwdata[BOUND_W-1:0];
                REG_FIVE_FOUR:  r_bound[1] <= pwdata[BOUND_W-1:0];
                REG_FOUR_THREE: r_bound[2] <= pwdata[BOUND_W-1:0];
                REG_THREE_TWO:  r_bound[3] <= pwdata[BOUND_W-1:0];
                REG_TWO_ONE:    r_bound[4] <= pwdata[BOUND_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_SIX_FIVE:   prdata = {{(32-BOUND_W){1'b0}}, r_bound[0]};
            REG_FIVE_FOUR:  prdata = {{(32-BOUND_W){1'b0}}, r_bound[1]};
            REG_FOUR_THREE: prdata = {{(32-BOUND_W){1'b0}}, r_bound[2]};
            REG_THREE_TWO:  prdata = {{(32-BOUND_W){1'b0}}, r_bound[3]};
            REG_TWO_ONE:    prdata = {{(32-BOUND_W){1'b0}}, r_bound[4]};
            default:        prdata = '0;
        endcase
    end

    assign b_is_engine = r_b_word.frame_id == ID_ENGINE_SPEED;
    assign b_is_trans  = r_b_word.frame_id == ID_TRANSMISSION;
    assign b_is_steer  = r_b_word.frame_id == ID_STEERING;
    assign b_is_brake  = r_b_word.frame_id == ID_BRAKE;
    assign b_is_report = r_b_word.frame_id == ID_REPORT;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign b_go       = r_b_valid && (!b_is_report || out_free);
    assign b_free     = !r_b_valid || b_go;
    assign a_free     = !r_a_valid || b_free;
    assign o_in_stall = !a_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_free) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_free) begin
            r_a_word <= i_in_word;
        end
    end

    assign a_speed = {1'b0, r_a_word.payload_low[31:16]} - SPEED_OFFSET;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_free) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_free) begin
            r_b_word <= r_a_word;
            for (int k = 0; k < NUM_BOUNDS; k++) begin
                r_b_product[k] <= PRODUCT_W'(r_bound[k]) * PRODUCT_W'(a_speed[15:0]);
            end
        end
    end

    assign b_rpm   = r_b_word.payload_high[31:16];
    assign b_speed = $signed({1'b0, r_b_word.payload_low[31:16]} - SPEED_OFFSET);
    assign b_lhs   = {{(PRODUCT_W-32){1'b0}}, b_rpm, 16'd0};

    always_comb begin
        n_gear_code = GEAR_ONE;
        for (int k = NUM_BOUNDS - 1; k >= 0; k--) begin
            if (b_lhs < r_b_product[k]) begin
                n_gear_code = GEAR_SIX - 4'(k);
            end
        end
        if (r_clutch_flag) begin
            n_gear_code = GEAR_CLUTCH;
        end else if (r_neutral_flag) begin
            n_gear_code = GEAR_NEUTRAL;
        end else if ((b_speed > -SPEED_DEAD && b_speed < SPEED_DEAD) || b_rpm < RPM_MIN) begin
            n_gear_code = GEAR_NEUTRAL;
        end else if (b_speed < 0) begin
            n_gear_code = GEAR_SIX;
        end
    end

    assign b_brake_diff = {{2{r_b_word.payload_high[31]}}, r_b_word.payload_high[31:16]}
                          - BRAKE_OFFSET;

    always_comb begin
        if (b_brake_diff < 0) begin
            n_brake_level = '0;
        end else if (b_brake_diff > BRAKE_HALF_MAX) begin
            n_brake_level = BRAKE_MAX;
        end else begin
            n_brake_level = {b_brake_diff[8:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_word    <= '0;
            r_rpm_word      <= '0;
            r_accel_byte    <= '0;
            r_gear_code     <= GEAR_NEUTRAL;
            r_clutch_flag   <= 1'b0;
            r_neutral_flag  <= 1'b0;
            r_steering_word <= '0;
            r_brake_level   <= '0;
        end else if (b_go) begin
            if (b_is_engine) begin
                r_rpm_word   <= b_rpm;
                r_speed_word <= r_b_word.payload_low[31:16];
                r_accel_byte <= r_b_word.payload_low[15:8];
                r_gear_code  <= n_gear_code;
            end else if (b_is_trans) begin
                r_clutch_flag  <= r_b_word.payload_high[17];
                r_neutral_flag <= r_b_word.payload_high[18];
            end else if (b_is_steer) begin
                r_steering_word <= r_b_word.payload_high[15:0];
            end else if (b_is_brake) begin
                r_brake_level <= n_brake_level;
            end
        end
    end

    always_comb begin
        n_out_word.speed_centi_kmh     = $signed({1'b0, r_speed_word} - SPEED_OFFSET);
        n_out_word.rpm_quarter         = r_rpm_word;
        n_out_word.gear_position       = r_gear_code;
        n_out_word.accel_half_percent  = r_accel_byte;
        n_out_word.brake_tenth_percent = r_brake_level;
        n_out_word.steering_raw        = $signed(r_steering_word);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_b_valid && b_is_report;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_b_valid && b_is_report) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

FILE: sv/cvsd_checker.sv
// Port-level checker for the CAN vehicle signal decoder, with its bind statement.
// Watches the output channel and the reported signal ranges over time.
// Depends on cvsd_pkg and binds to can_vehicle_signal_decoder.
`default_nettype none

module cvsd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input cvsd_pkg::t_out_word o_out_word
);
    import cvsd_pkg::*;

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_word))
        else $error("output word changed while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("pipeline not cleared by reset");

    a_gear_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.gear_position <= GEAR_SIX
                         || o_out_word.gear_position == GEAR_CLUTCH))
        else $error("reported gear out of range");

    a_brake_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_in_valid) |-> (o_out_word.brake_tenth_percent <= BRAKE_MAX))
        else $error("reported brake level above saturation");

endmodule

bind can_vehicle_signal_decoder cvsd_checker u_cvsd_checker (.*);

`default_nettype wire
